/* rtl/core/c3f_pkg.sv */
// c3f_pkg: shared constants, register codes and transfer types of the
// 3x3 convolution filter. No dependencies.
package c3f_pkg;

    localparam int C3F_MAX_WIDTH = 1024;
    localparam int KERNEL_SIZE   = 3;
    localparam int KERNEL_TAPS   = KERNEL_SIZE * KERNEL_SIZE;
    localparam int CENTER_TAP    = KERNEL_TAPS / 2;

    localparam int PIX_W    = 8;
    localparam int COEFF_W  = 5;
    localparam int COEFFS_W = KERNEL_TAPS * COEFF_W;
    localparam int IMG_W_W  = 10;
    localparam int IMG_H_W  = 12;
    localparam int ROW_W    = 12;
    localparam int HGT_W    = 13;
    localparam int MAX_HEIGHT = 4094;

    localparam logic [COEFFS_W-1:0] KERNEL_RESET = 45'd1134979744801;
    localparam logic [IMG_W_W-1:0]  WIDTH_RESET  = 10'd640;
    localparam logic [IMG_H_W-1:0]  HEIGHT_RESET = 12'd480;

    localparam int PROD_W      = 14;
    localparam int ROWSUM_W    = 16;
    localparam int SUM_W       = 17;
    localparam int RECIP_W     = 16;
    localparam int MUL_W       = 32;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_9 = 16'd58255;
    localparam int PIX_MAX     = 255;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 8;

    typedef enum logic [1:0] {
        CFG_KERNEL  = 2'd0,
        CFG_WIDTH   = 2'd1,
        CFG_HEIGHT  = 2'd2,
        CFG_SHARPEN = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [IMG_W_W-1:0] width;
        logic [IMG_H_W-1:0] height;
    } c3f_geom_t;

    typedef struct packed {
        logic [COEFFS_W-1:0] coeffs;
        logic                sharpen;
    } c3f_filt_cfg_t;

    typedef struct packed {
        logic [KERNEL_TAPS-1:0][PIX_W-1:0] win;
        logic                              last;
    } c3f_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } c3f_result_t;

endpackage

/* rtl/core/c3f_fifo.sv */
// c3f_fifo: small register queue with occupancy count.
// Depends on nothing; used for the window queue and the result queue.
module c3f_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign empty    = (count_reg == '0);
    assign count    = count_reg;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CNT_W'(DEPTH)))
        else $error("push into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

/* rtl/core/c3f_front.sv */
// c3f_front: pixel intake, frame position tracking, line stores and window.
// Depends on c3f_pkg; pushes complete windows into the window queue.
module c3f_front #(
    parameter int MAX_WIDTH = c3f_pkg::C3F_MAX_WIDTH
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    push,
    input  logic [c3f_pkg::PIX_W-1:0]               pixel_in,
    output logic                                    full,
    input  c3f_pkg::c3f_geom_t                      geom,
    input  logic [$clog2(c3f_pkg::MID_DEPTH+1)-1:0] q_count,
    output logic                                    q_push,
    output c3f_pkg::c3f_item_t                      q_item
);
    import c3f_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int PW_W  = $clog2(MAX_WIDTH + 1);
    localparam int GEO_W = (PW_W > IMG_W_W) ? PW_W : IMG_W_W;
    localparam int QC_W  = $clog2(MID_DEPTH + 1);

    logic                 accept;
    logic [GEO_W-1:0]     w_ext, w_clamp;
    logic [PW_W-1:0]      pw;
    logic [IMG_H_W-1:0]   h_clamp;
    logic [HGT_W-1:0]     ph;

    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic                 wrap_in;
    logic [COL_W-1:0]     c_cur;
    logic [HGT_W-1:0]     r_inc, r_cur, r_plus;
    logic [PW_W-1:0]      c_plus;
    logic                 c_end, r_end, emit, last;

    logic                 a_valid_reg, a_emit_reg, a_last_reg;
    logic [COL_W-1:0]     a_col_reg;
    logic [PIX_W-1:0]     a_pix_reg;
    logic [QC_W:0]        pending;

    logic [2*PIX_W-1:0]   ls_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0]   rd_data_reg;

    logic [KERNEL_TAPS-1:0][PIX_W-1:0] win_reg, win_next;
    logic [KERNEL_SIZE-1:0][PIX_W-1:0] new_col;

    // clamped padded geometry
    always_comb
    begin
        w_ext = GEO_W'(geom.width);
        if (w_ext == '0)
        begin
            w_clamp = GEO_W'(1);
        end
        else if (w_ext > GEO_W'(MAX_WIDTH - 2))
        begin
            w_clamp = GEO_W'(MAX_WIDTH - 2);
        end
        else
        begin
            w_clamp = w_ext;
        end
        pw = PW_W'(w_clamp) + PW_W'(2);

        if (geom.height == '0)
        begin
            h_clamp = IMG_H_W'(1);
        end
        else if (geom.height > IMG_H_W'(MAX_HEIGHT))
        begin
            h_clamp = IMG_H_W'(MAX_HEIGHT);
        end
        else
        begin
            h_clamp = geom.height;
        end
        ph = HGT_W'(h_clamp) + HGT_W'(2);
    end

    // frame position of the incoming pixel
    always_comb
    begin
        wrap_in = (PW_W'(col_reg) >= pw);
        c_cur   = wrap_in ? '0 : col_reg;
        r_inc   = HGT_W'(row_reg) + (wrap_in ? HGT_W'(1) : HGT_W'(0));
        r_cur   = (r_inc >= ph) ? '0 : r_inc;
        c_plus  = PW_W'(c_cur) + PW_W'(1);
        r_plus  = r_cur + HGT_W'(1);
        c_end   = (c_plus >= pw);
        r_end   = (r_plus >= ph);
        emit    = (r_cur >= HGT_W'(2)) && (c_cur >= COL_W'(2));
        last    = r_end && c_end;
        if (c_end)
        begin
            col_next = '0;
            row_next = r_end ? '0 : ROW_W'(r_plus);
        end
        else
        begin
            col_next = COL_W'(c_plus);
            row_next = ROW_W'(r_cur);
        end
    end

    assign pending = (QC_W + 1)'(q_count) + (QC_W + 1)'(a_valid_reg && a_emit_reg);
    assign full    = (pending >= (QC_W + 1)'(MID_DEPTH));
    assign accept  = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
            a_emit_reg  <= 1'b0;
            a_last_reg  <= 1'b0;
            win_reg     <= '0;
        end
        else
        begin
            a_valid_reg <= accept;
            if (accept)
            begin
                col_reg    <= col_next;
                row_reg    <= row_next;
                a_emit_reg <= emit;
                a_last_reg <= last;
            end
            if (a_valid_reg)
            begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_col_reg <= c_cur;
            a_pix_reg <= pixel_in;
        end
    end

    // line stores: upper line in the high byte, middle line in the low byte
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= ls_mem[c_cur];
        end
        if (a_valid_reg)
        begin
            ls_mem[a_col_reg] <= {rd_data_reg[PIX_W-1:0], a_pix_reg};
        end
    end

    assign new_col[0] = rd_data_reg[2*PIX_W-1:PIX_W];
    assign new_col[1] = rd_data_reg[PIX_W-1:0];
    assign new_col[2] = a_pix_reg;

    always_comb
    begin
        win_next = win_reg;
        for (int r = 0; r < KERNEL_SIZE; r++)
        begin
            for (int c = 0; c < KERNEL_SIZE - 1; c++)
            begin
                win_next[r*KERNEL_SIZE+c] = win_reg[r*KERNEL_SIZE+c+1];
            end
            win_next[r*KERNEL_SIZE+KERNEL_SIZE-1] = new_col[r];
        end
    end

    assign q_push      = a_valid_reg && a_emit_reg;
    assign q_item.win  = win_next;
    assign q_item.last = a_last_reg;

    a_push_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> $past(push && !full))
        else $error("window pushed without an accepted pixel");

endmodule

/* rtl/core/c3f_back.sv */
// c3f_back: multiply-accumulate, divide by nine, clamp and sharpen.
// Depends on c3f_pkg; drains the window queue into the result queue.
module c3f_back (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    q_empty,
    input  c3f_pkg::c3f_item_t                      q_item,
    output logic                                    q_pop,
    input  c3f_pkg::c3f_filt_cfg_t                  cfg,
    input  logic [$clog2(c3f_pkg::OUT_DEPTH+1)-1:0] out_count,
    output logic                                    o_push,
    output c3f_pkg::c3f_result_t                    o_data
);
    import c3f_pkg::*;

    localparam int OC_W = $clog2(OUT_DEPTH + 1);
    localparam int Q_W  = MUL_W - RECIP_SHIFT;

    logic [OC_W:0] inflight;

    logic signed [PROD_W-1:0] px_s [KERNEL_TAPS];
    logic signed [PROD_W-1:0] cf_s [KERNEL_TAPS];
    logic signed [PROD_W-1:0] prod_next [KERNEL_TAPS];
    logic signed [ROWSUM_W-1:0] row_next [KERNEL_SIZE];
    logic signed [SUM_W-1:0]  sum_next;

    logic                     s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic signed [PROD_W-1:0] s1_prod_reg [KERNEL_TAPS];
    logic signed [ROWSUM_W-1:0] s2_row_reg [KERNEL_SIZE];
    logic signed [SUM_W-1:0]  s3_sum_reg;
    logic                     s4_neg_reg;
    logic [MUL_W-1:0]         s4_prod_reg;
    logic [PIX_W-1:0]         s1_ctr_reg, s2_ctr_reg, s3_ctr_reg, s4_ctr_reg;
    logic                     s1_last_reg, s2_last_reg, s3_last_reg, s4_last_reg;

    logic [Q_W-1:0]           quot;
    logic [PIX_W-1:0]         filt;

    assign inflight = (OC_W + 1)'(out_count) + (OC_W + 1)'(s1_valid_reg)
                    + (OC_W + 1)'(s2_valid_reg) + (OC_W + 1)'(s3_valid_reg)
                    + (OC_W + 1)'(s4_valid_reg);
    assign q_pop    = !q_empty && (inflight < (OC_W + 1)'(OUT_DEPTH));

    always_comb
    begin
        for (int k = 0; k < KERNEL_TAPS; k++)
        begin
            px_s[k] = {{(PROD_W - PIX_W){1'b0}}, q_item.win[k]};
            cf_s[k] = {{(PROD_W - COEFF_W){cfg.coeffs[k*COEFF_W+COEFF_W-1]}},
                       cfg.coeffs[k*COEFF_W +: COEFF_W]};
            prod_next[k] = px_s[k] * cf_s[k];
        end
    end

    always_comb
    begin
        for (int r = 0; r < KERNEL_SIZE; r++)
        begin
            row_next[r] = '0;
            for (int c = 0; c < KERNEL_SIZE; c++)
            begin
                row_next[r] = row_next[r]
                    + {{(ROWSUM_W - PROD_W){s1_prod_reg[r*KERNEL_SIZE+c][PROD_W-1]}},
                       s1_prod_reg[r*KERNEL_SIZE+c]};
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int r = 0; r < KERNEL_SIZE; r++)
        begin
            sum_next = sum_next
                + {{(SUM_W - ROWSUM_W){s2_row_reg[r][ROWSUM_W-1]}}, s2_row_reg[r]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= q_pop;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < KERNEL_TAPS; k++)
        begin
            s1_prod_reg[k] <= prod_next[k];
        end
        s1_ctr_reg  <= q_item.win[CENTER_TAP];
        s1_last_reg <= q_item.last;

        for (int r = 0; r < KERNEL_SIZE; r++)
        begin
            s2_row_reg[r] <= row_next[r];
        end
        s2_ctr_reg  <= s1_ctr_reg;
        s2_last_reg <= s1_last_reg;

        s3_sum_reg  <= sum_next;
        s3_ctr_reg  <= s2_ctr_reg;
        s3_last_reg <= s2_last_reg;

        // divide by nine through the reciprocal, exact below 2^16
        s4_neg_reg  <= s3_sum_reg[SUM_W-1];
        s4_prod_reg <= MUL_W'(s3_sum_reg[RECIP_W-1:0]) * MUL_W'(RECIP_9);
        s4_ctr_reg  <= s3_ctr_reg;
        s4_last_reg <= s3_last_reg;
    end

    always_comb
    begin
        quot = s4_prod_reg[MUL_W-1:RECIP_SHIFT];
        if (s4_neg_reg)
        begin
            filt = '0;
        end
        else if (quot > Q_W'(PIX_MAX))
        begin
            filt = PIX_W'(PIX_MAX);
        end
        else
        begin
            filt = quot[PIX_W-1:0];
        end
        o_data.pixel = cfg.sharpen ? filt + s4_ctr_reg : filt;
        o_data.last  = s4_last_reg;
    end

    assign o_push = s4_valid_reg;

    a_pipe_latency: assert property (@(posedge clk) disable iff (!rst_n)
        o_push |-> $past(q_pop, 4))
        else $error("result without a window four cycles earlier");

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight <= (OC_W + 1)'(OUT_DEPTH))
        else $error("results in flight exceed result queue space");

endmodule

/* rtl/core/conv3x3_image_filter.sv */
// conv3x3_image_filter: top level of the 3x3 convolution filter.
// Depends on c3f_pkg, c3f_fifo, c3f_front and c3f_back.
//
//  channel   handshake                 payload
//  input     push / full               pixel_in
//  result    pop / empty               pixel_out, last_of_frame
//  config    cfg_write                 cfg_index, cfg_data
//
// one pixel per clock sustained while full stays low; a result is readable
// after the line store read, the window queue and four arithmetic stages
// reset clears position counters, window, queues and registers; line stores
// are not cleared and need no clearing pass
// full rises when the window queue plus the read stage hold four windows;
// the arithmetic stages stop drawing when they and the result queue hold eight
module conv3x3_image_filter #(
    parameter int MAX_WIDTH = c3f_pkg::C3F_MAX_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [c3f_pkg::PIX_W-1:0]      pixel_in,
    output logic                           empty,
    input  logic                           pop,
    output logic [c3f_pkg::PIX_W-1:0]      pixel_out,
    output logic                           last_of_frame,
    input  logic                           cfg_write,
    input  logic [1:0]                     cfg_index,
    input  logic [c3f_pkg::COEFFS_W-1:0]   cfg_data
);
    import c3f_pkg::*;

    localparam int MQ_W = $clog2(MID_DEPTH + 1);
    localparam int OQ_W = $clog2(OUT_DEPTH + 1);

    logic [COEFFS_W-1:0] kernel_coeffs_reg;
    logic [IMG_W_W-1:0]  image_width_reg;
    logic [IMG_H_W-1:0]  image_height_reg;
    logic                sharpen_mode_reg;

    c3f_geom_t     geom;
    c3f_filt_cfg_t filt_cfg;

    logic          mq_push, mq_pop, mq_empty;
    c3f_item_t     mq_in, mq_out;
    logic [MQ_W-1:0] mq_count;

    logic          oq_push;
    c3f_result_t   oq_in, oq_out;
    logic [OQ_W-1:0] oq_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_coeffs_reg <= KERNEL_RESET;
            image_width_reg   <= WIDTH_RESET;
            image_height_reg  <= HEIGHT_RESET;
            sharpen_mode_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_KERNEL:  kernel_coeffs_reg <= cfg_data;
                CFG_WIDTH:   image_width_reg   <= cfg_data[IMG_W_W-1:0];
                CFG_HEIGHT:  image_height_reg  <= cfg_data[IMG_H_W-1:0];
                CFG_SHARPEN: sharpen_mode_reg  <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    assign geom.width       = image_width_reg;
    assign geom.height      = image_height_reg;
    assign filt_cfg.coeffs  = kernel_coeffs_reg;
    assign filt_cfg.sharpen = sharpen_mode_reg;

    c3f_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pixel_in (pixel_in),
        .full     (full),
        .geom     (geom),
        .q_count  (mq_count),
        .q_push   (mq_push),
        .q_item   (mq_in)
    );

    c3f_fifo #(
        .WIDTH ($bits(c3f_item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mq_push),
        .push_data (mq_in),
        .pop       (mq_pop),
        .pop_data  (mq_out),
        .empty     (mq_empty),
        .count     (mq_count)
    );

    c3f_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (mq_empty),
        .q_item    (mq_out),
        .q_pop     (mq_pop),
        .cfg       (filt_cfg),
        .out_count (oq_count),
        .o_push    (oq_push),
        .o_data    (oq_in)
    );

    c3f_fifo #(
        .WIDTH ($bits(c3f_result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (oq_push),
        .push_data (oq_in),
        .pop       (pop),
        .pop_data  (oq_out),
        .empty     (empty),
        .count     (oq_count)
    );

    assign pixel_out     = oq_out.pixel;
    assign last_of_frame = oq_out.last;

endmodule
